### rtl/core/fpr_pkg.sv
package fpr_pkg;

  // Engine sizing
  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 2;
  localparam int ADDR_BITS = 8;

  // Field widths
  localparam int ADDR_W  = 8;
  localparam int TAG_W   = 6;
  localparam int FRAME_W = 4;
  localparam int COUNT_W = 16;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  localparam logic [ADDR_W-1:0]  ADDR_MASK = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(FRAMES - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Sequencer step codes
  typedef logic [2:0] step_t;
  localparam int    NSTEPS     = 8;
  localparam step_t STEP_WAIT  = 3'd0;
  localparam step_t STEP_PRIME = 3'd1;
  localparam step_t STEP_SCAN  = 3'd2;
  localparam step_t STEP_FRD   = 3'd3;
  localparam step_t STEP_FWR   = 3'd4;
  localparam step_t STEP_HIT   = 3'd5;
  localparam step_t STEP_SPARE = 3'd6;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_IDX,
    RD_OLDEST
  } rd_sel_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP,
    OP_SCAN,
    OP_FILL,
    OP_HIT
  } op_e;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_FIRE,
    COND_SCAN,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic    in_ready;
    rd_sel_e rd_sel;
    op_e     op;
    cond_e   cond;
    step_t   jmp;
    step_t   nxt;
  } ucode_t;

  typedef struct packed {
    logic fire;
    logic match;
    logic last;
    logic out_free;
  } seq_flags_t;

  // Control store: one word per step
  localparam ucode_t UCODE [NSTEPS] = '{
    '{1'b1, RD_NONE,   OP_LOAD, COND_FIRE,     STEP_PRIME, STEP_WAIT},
    '{1'b0, RD_IDX,    OP_STEP, COND_ALWAYS,   STEP_SCAN,  STEP_SCAN},
    '{1'b0, RD_IDX,    OP_SCAN, COND_SCAN,     STEP_HIT,   STEP_FRD},
    '{1'b0, RD_OLDEST, OP_NONE, COND_ALWAYS,   STEP_FWR,   STEP_FWR},
    '{1'b0, RD_OLDEST, OP_FILL, COND_OUT_FREE, STEP_WAIT,  STEP_WAIT},
    '{1'b0, RD_NONE,   OP_HIT,  COND_OUT_FREE, STEP_WAIT,  STEP_WAIT},
    '{1'b0, RD_NONE,   OP_NONE, COND_ALWAYS,   STEP_WAIT,  STEP_WAIT},
    '{1'b0, RD_NONE,   OP_NONE, COND_ALWAYS,   STEP_WAIT,  STEP_WAIT}
  };

  // Slot index to frame field, modulo 16
  function automatic logic [FRAME_W-1:0] to_frame(input logic [IDX_W-1:0] idx);
    logic [IDX_W+FRAME_W-1:0] ext;
    ext = {{FRAME_W{1'b0}}, idx};
    return ext[FRAME_W-1:0];
  endfunction

endpackage

### rtl/core/fifo_page_replacement_top.sv
// Channel | Direction | Handshake              | Beat payload
// --------+-----------+------------------------+----------------------------------------------
// in      | sink      | in_valid_i / in_stall_o   | address_i
// out     | source    | out_valid_o / out_stall_i | hit_o, frame_o, evicted_o, evicted_page_o,
//         |           |                           | fault_count_o
//
// Turnaround: the next address is taken only after the current lookup ends; a
//   hit ends the frame scan at its slot, while a fault scans all FRAMES slots. The
//   frame scan reads one tag memory word per cycle through a registered read port.
// Reset: async active low; clears valid bits, FIFO pointer and fault counter.
//   Tag memory is not cleared; valid bits mask stale tags.
// Stalls: the result register holds one beat; a new address is taken while it
//   waits, and the sequencer only stalls when a second result is ready.
module fifo_page_replacement_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fpr_pkg::ADDR_W-1:0]   address_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [fpr_pkg::FRAME_W-1:0]  frame_o,
  output logic                         evicted_o,
  output logic [fpr_pkg::TAG_W-1:0]    evicted_page_o,
  output logic [fpr_pkg::COUNT_W-1:0]  fault_count_o
);

  fpr_pkg::ucode_t     ctrl;
  fpr_pkg::seq_flags_t flags;

  // Tag store and scan datapath
  logic [fpr_pkg::TAG_W-1:0]   tag_mem [fpr_pkg::FRAMES];
  logic [fpr_pkg::TAG_W-1:0]   tag_rd_q;
  logic [fpr_pkg::FRAMES-1:0]  slot_valid_q;
  logic [fpr_pkg::IDX_W-1:0]   oldest_q, oldest_d;
  logic [fpr_pkg::IDX_W-1:0]   idx_q;     // read pointer
  logic [fpr_pkg::IDX_W-1:0]   cmp_q;     // slot whose tag sits in tag_rd_q
  logic [fpr_pkg::IDX_W-1:0]   idx_inc;
  logic [fpr_pkg::IDX_W-1:0]   rd_addr;
  logic [fpr_pkg::TAG_W-1:0]   page_q;
  logic [fpr_pkg::TAG_W-1:0]   page_in;
  logic [fpr_pkg::ADDR_W-1:0]  addr_sh;
  logic [fpr_pkg::COUNT_W-1:0] faults_q, faults_d;

  logic fire, match, last, out_free, rd_en, fill_en, hit_en, evict;

  // Result register
  logic                        out_valid_q;
  logic                        hit_q, evicted_q;
  logic [fpr_pkg::FRAME_W-1:0] frame_q;
  logic [fpr_pkg::TAG_W-1:0]   ev_page_q;
  logic [fpr_pkg::COUNT_W-1:0] count_q;

  fpr_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign fire       = in_valid_i & ctrl.in_ready;
  assign in_stall_o = ~ctrl.in_ready;

  assign addr_sh = (address_i & fpr_pkg::ADDR_MASK) >> fpr_pkg::PAGE_BITS;
  assign page_in = addr_sh[fpr_pkg::TAG_W-1:0];

  assign match    = slot_valid_q[cmp_q] & (tag_rd_q == page_q);
  assign last     = (cmp_q == fpr_pkg::LAST_IDX);
  assign out_free = ~out_valid_q | ~out_stall_i;

  assign flags = '{fire: fire, match: match, last: last, out_free: out_free};

  // Pointer stops at the last slot so the read address stays in range
  assign idx_inc  = (idx_q == fpr_pkg::LAST_IDX) ? idx_q : idx_q + 1'b1;
  assign oldest_d = (oldest_q == fpr_pkg::LAST_IDX) ? '0 : oldest_q + 1'b1;
  assign faults_d = (faults_q == fpr_pkg::COUNT_MAX) ? faults_q : faults_q + 1'b1;

  assign rd_en   = (ctrl.rd_sel != fpr_pkg::RD_NONE);
  assign rd_addr = (ctrl.rd_sel == fpr_pkg::RD_OLDEST) ? oldest_q : idx_q;
  assign fill_en = (ctrl.op == fpr_pkg::OP_FILL) & out_free;
  assign hit_en  = (ctrl.op == fpr_pkg::OP_HIT) & out_free;
  assign evict   = slot_valid_q[oldest_q];

  // Tag memory: one read, one write per cycle; read is read-before-write
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      tag_rd_q <= tag_mem[rd_addr];
    end
    if (fill_en) begin
      tag_mem[oldest_q] <= page_q;
    end
  end

  // Scan pointers and latched page
  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      fpr_pkg::OP_LOAD: begin
        if (fire) begin
          page_q <= page_in;
          idx_q  <= '0;
        end
      end
      fpr_pkg::OP_STEP: begin
        cmp_q <= idx_q;
        idx_q <= idx_inc;
      end
      fpr_pkg::OP_SCAN: begin
        if (!match) begin
          cmp_q <= idx_q;
          idx_q <= idx_inc;
        end
      end
      default: ;
    endcase
  end

  // Replacement state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      oldest_q     <= '0;
      faults_q     <= '0;
    end else if (fill_en) begin
      slot_valid_q[oldest_q] <= 1'b1;
      oldest_q               <= oldest_d;
      faults_q               <= faults_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fill_en || hit_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_en) begin
      hit_q     <= 1'b0;
      frame_q   <= fpr_pkg::to_frame(oldest_q);
      evicted_q <= evict;
      ev_page_q <= evict ? tag_rd_q : '0;
      count_q   <= faults_d;
    end else if (hit_en) begin
      hit_q     <= 1'b1;
      frame_q   <= fpr_pkg::to_frame(cmp_q);
      evicted_q <= 1'b0;
      ev_page_q <= '0;
      count_q   <= faults_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign frame_o        = frame_q;
  assign evicted_o      = evicted_q;
  assign evicted_page_o = ev_page_q;
  assign fault_count_o  = count_q;

  // A hit never replaces a page
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("hit beat reports an eviction");

  // Fault counter never goes backward
  a_faults_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    faults_q >= $past(faults_q))
    else $error("fault counter decreased");

  // FIFO pointer moves only on a fill
  a_oldest_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(oldest_q) |-> $past(fill_en))
    else $error("oldest pointer moved without a fill");

  // A filled slot is valid afterwards
  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_en |=> slot_valid_q[$past(oldest_q)])
    else $error("filled slot not marked valid");

endmodule

### rtl/core/fpr_seq.sv
module fpr_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpr_pkg::seq_flags_t flags_i,
  output fpr_pkg::ucode_t     ctrl_o
);

  fpr_pkg::step_t  step_q, step_d;
  fpr_pkg::ucode_t uw;

  assign uw     = fpr_pkg::UCODE[step_q];
  assign ctrl_o = uw;

  always_comb begin
    case (uw.cond)
      fpr_pkg::COND_ALWAYS:   step_d = uw.jmp;
      fpr_pkg::COND_FIRE:     step_d = flags_i.fire ? uw.jmp : step_q;
      fpr_pkg::COND_SCAN: begin
        if (flags_i.match) begin
          step_d = uw.jmp;
        end else if (flags_i.last) begin
          step_d = uw.nxt;
        end else begin
          step_d = step_q;
        end
      end
      fpr_pkg::COND_OUT_FREE: step_d = flags_i.out_free ? uw.jmp : step_q;
      default:                step_d = fpr_pkg::STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= fpr_pkg::STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

### verif/fpr_checker.sv
// Watches both channels of the FIFO page replacement engine, tracks the frame
// table on its own and compares every result beat with the oldest prediction.
module fpr_checker
  import fpr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               hit_i,
  input  logic [FRAME_W-1:0] frame_i,
  input  logic               evicted_i,
  input  logic [TAG_W-1:0]   evicted_page_i,
  input  logic [COUNT_W-1:0] fault_count_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 hits_o,
  output int                 evictions_o,
  output logic               saturated_o
);

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted;
    logic [TAG_W-1:0]   evicted_page;
    logic [COUNT_W-1:0] fault_count;
  } lookup_result_t;

  // Shadow of the engine state
  logic [TAG_W-1:0]   tag_mem   [FRAMES];
  logic               slot_live [FRAMES];
  int                 fifo_ptr;
  logic [COUNT_W-1:0] fault_total;

  lookup_result_t expected_lookups [$];
  int             mismatches;
  int             result_cnt;
  int             hit_cnt;
  int             evict_cnt;

  function automatic lookup_result_t fifo_lookup(input logic [ADDR_W-1:0] addr);
    lookup_result_t r;
    logic [ADDR_W-1:0] masked;
    logic [TAG_W-1:0]  page;
    int                slot;
    r      = '0;
    masked = addr & ADDR_MASK;
    page   = TAG_W'(masked >> PAGE_BITS);
    for (int i = 0; i < FRAMES; i++) begin
      if (!r.hit && slot_live[i] && tag_mem[i] == page) begin
        r.hit   = 1'b1;
        r.frame = FRAME_W'(i);
      end
    end
    if (!r.hit) begin
      if (fault_total != COUNT_MAX) fault_total++;
      slot    = fifo_ptr;
      r.frame = FRAME_W'(slot);
      if (slot_live[slot]) begin
        r.evicted      = 1'b1;
        r.evicted_page = tag_mem[slot];
      end
      tag_mem[slot]   = page;
      slot_live[slot] = 1'b1;
      fifo_ptr        = (slot == FRAMES - 1) ? 0 : slot + 1;
    end
    r.fault_count = fault_total;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t exp_r;
    lookup_result_t act_r;
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES; i++) begin
        tag_mem[i]   = '0;
        slot_live[i] = 1'b0;
      end
      fifo_ptr    = 0;
      fault_total = '0;
      expected_lookups.delete();
      mismatches  = 0;
      result_cnt  = 0;
      hit_cnt     = 0;
      evict_cnt   = 0;
      errors_o    <= 0;
      pending_o   <= 0;
      results_o   <= 0;
      hits_o      <= 0;
      evictions_o <= 0;
      saturated_o <= 1'b0;
    end else begin
      // Output side first: a beat leaving now never belongs to one entering now.
      if (out_valid_i && !out_stall_i) begin
        act_r = '{hit_i, frame_i, evicted_i, evicted_page_i, fault_count_i};
        result_cnt++;
        if (expected_lookups.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] ERROR: result beat with nothing pending: hit=%0d frame=%0d",
                     $realtime, hit_i, frame_i);
          mismatches++;
        end else begin
          exp_r = expected_lookups.pop_front();
          if (exp_r.hit) hit_cnt++;
          if (exp_r.evicted) evict_cnt++;
          if (act_r !== exp_r) begin
            if (mismatches < 10) begin
              $display("[%0t] ERROR beat %0d exp hit=%0d frame=%0d ev=%0d pg=%0d faults=%0d",
                       $realtime, result_cnt, exp_r.hit, exp_r.frame, exp_r.evicted,
                       exp_r.evicted_page, exp_r.fault_count);
              $display("      got hit=%0d frame=%0d ev=%0d pg=%0d faults=%0d",
                       act_r.hit, act_r.frame, act_r.evicted, act_r.evicted_page,
                       act_r.fault_count);
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_lookups = {expected_lookups, fifo_lookup(address_i)};
      errors_o    <= mismatches;
      pending_o   <= expected_lookups.size();
      results_o   <= result_cnt;
      hits_o      <= hit_cnt;
      evictions_o <= evict_cnt;
      saturated_o <= (fault_total == COUNT_MAX);
    end
  end

endmodule

### verif/testbench.sv
// Top of the page replacement bench: clock, reset, address stimulus and the
// result-side stall pattern. Result checking lives in fpr_checker.
module testbench;
  import fpr_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int NUM_PAGES    = 1 << TAG_W;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [ADDR_W-1:0]  address;
  logic               out_valid;
  logic               out_stall;
  logic               hit;
  logic [FRAME_W-1:0] frame;
  logic               evicted;
  logic [TAG_W-1:0]   evicted_page;
  logic [COUNT_W-1:0] fault_count;

  int   chk_errors;
  int   chk_pending;
  int   chk_results;
  int   chk_hits;
  int   chk_evictions;
  logic chk_saturated;

  int   addr_beats;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  fifo_page_replacement_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .address_i      (address),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .hit_o          (hit),
    .frame_o        (frame),
    .evicted_o      (evicted),
    .evicted_page_o (evicted_page),
    .fault_count_o  (fault_count)
  );

  fpr_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .address_i      (address),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .hit_i          (hit),
    .frame_i        (frame),
    .evicted_i      (evicted),
    .evicted_page_i (evicted_page),
    .fault_count_i  (fault_count),
    .errors_o       (chk_errors),
    .pending_o      (chk_pending),
    .results_o      (chk_results),
    .hits_o         (chk_hits),
    .evictions_o    (chk_evictions),
    .saturated_o    (chk_saturated)
  );

  // Offer one address beat and hold it until the engine takes it. valid
  // stays high on return, so back-to-back beats never drop it.
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    in_valid <= 1'b1;
    address  <= addr;
    do @(posedge clk); while (in_stall);
    addr_beats++;
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic logic [ADDR_W-1:0] page_address(input int page);
    logic [ADDR_W-1:0] offs;
    offs = ADDR_W'($urandom_range(0, (1 << PAGE_BITS) - 1));
    return ADDR_W'(((page % NUM_PAGES) << PAGE_BITS) | offs);
  endfunction

  // Random address mix: mostly a sliding window of 20 pages over 16 frames,
  // which gives both hits and evictions; the rest is uniform noise.
  int win_base;
  function automatic logic [ADDR_W-1:0] pick_address();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return page_address(win_base + $urandom_range(0, 19));
    if (roll < 85) return page_address($urandom_range(0, NUM_PAGES - 1));
    return ADDR_W'($urandom);
  endfunction

  // Result side: a random stall mode for each segment, plus one long
  // hold-off while the sender keeps pushing so the engine backs up.
  initial begin
    int  mode;
    bit  held;
    bit  toggle;
    out_stall = 1'b0;
    held      = 1'b0;
    toggle    = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && chk_results >= 400) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        held = 1'b1;
      end
      mode = $urandom_range(0, 3);
      repeat (64) begin
        toggle = ~toggle;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= toggle;
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int burst;
    int sent;
    int drain;
    in_valid   = 1'b0;
    address    = '0;
    rst_n      = 1'b0;
    addr_beats = 0;
    win_base   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first fault into empty slot 0, then the same page through
    // other offset bits (hit), fill every frame, wrap the FIFO pointer and
    // evict, hit in the last slot, and the all-ones address.
    send_address(ADDR_W'(0));
    send_address(ADDR_W'(3));
    for (int p = 1; p < FRAMES; p++) send_address(page_address(p));
    send_address(ADDR_W'(255));
    send_address(page_address(FRAMES - 1));
    send_address(ADDR_W'(0));
    send_address(ADDR_W'(7));
    idle_sender(5);

    // Random traffic in bursts with gaps
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      if ($urandom_range(0, 7) == 0) win_base = $urandom_range(0, NUM_PAGES - 1);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        send_address(pick_address());
        sent++;
      end
      idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // Drain, then allow the engine's worst-case turnaround to pass
    drain = 0;
    while (chk_pending != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);

    $display("Run covered %0d address beats, %0d results: %0d hits, %0d evictions.",
             addr_beats, chk_results, chk_hits, chk_evictions);
    $display("Long output hold-off applied; fault counter saturated: %0d, beats left: %0d.",
             chk_saturated, chk_pending);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(8 * 5_000_000);
    $display("Timeout with %0d beats outstanding", chk_pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
rtl/core/fpr_pkg.sv
rtl/core/fpr_seq.sv
rtl/core/fifo_page_replacement_top.sv
verif/fpr_checker.sv
verif/testbench.sv
